// ===== sv/gpaa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the gimbal converter: constants, arctangent table and rounding helpers.
package gpaa_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int SQRT_STEPS = 17;
    localparam logic [14:0] MAX_DEFL_RESET = 15'd1536;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

    function automatic logic signed [31:0] atan_val(input int idx);
        logic signed [31:0] v;
        begin
            unique case (idx)
                0: v = 32'sd188743680;
                1: v = 32'sd111421900;
                2: v = 32'sd58872272;
                3: v = 32'sd29884485;
                4: v = 32'sd15000234;
                5: v = 32'sd7507429;
                6: v = 32'sd3754631;
                7: v = 32'sd1877430;
                8: v = 32'sd938729;
                9: v = 32'sd469366;
                10: v = 32'sd234683;
                11: v = 32'sd117342;
                12: v = 32'sd58671;
                13: v = 32'sd29335;
                14: v = 32'sd14668;
                15: v = 32'sd7334;
                16: v = 32'sd3667;
                17: v = 32'sd1833;
                18: v = 32'sd917;
                19: v = 32'sd458;
                20: v = 32'sd229;
                21: v = 32'sd115;
                22: v = 32'sd57;
                23: v = 32'sd29;
                default: v = 32'sd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [17:0] rnd_q16(input logic signed [33:0] v);
        logic signed [33:0] t;
        begin
            t = (v + 34'sd8192) >>> 14;
            if (t > 34'sd65536) begin
                t = 34'sd65536;
            end else if (t < -34'sd65536) begin
                t = -34'sd65536;
            end
            return t[17:0];
        end
    endfunction

    function automatic logic signed [17:0] rnd_prod(input logic signed [35:0] v);
        logic signed [35:0] t;
        begin
            t = (v + 36'sd32768) >>> 16;
            if (t > 36'sd65536) begin
                t = 36'sd65536;
            end else if (t < -36'sd65536) begin
                t = -36'sd65536;
            end
            return t[17:0];
        end
    endfunction

    function automatic logic signed [15:0] rnd_ang(input logic signed [31:0] v);
        logic signed [31:0] t;
        begin
            t = (v + 32'sd8192) >>> 14;
            if (t > 32'sd23040) begin
                t = 32'sd23040;
            end else if (t < -32'sd23040) begin
                t = -32'sd23040;
            end
            return t[15:0];
        end
    endfunction

endpackage

// ===== sv/gimbal_polar_to_axis_angles_top.sv =====
`timescale 1ns / 1ps
// Pipelined polar gimbal command to two actuator axis angles converter.
// One word enters per cycle while o_stall is low; the two CORDICs and the square root are fully unrolled.
// A stalled output word freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears all valid bits and loads the deflection limit with 6.0 degrees.
module gimbal_polar_to_axis_angles_top #(
    parameter int CORDIC_STAGES = gpaa_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [14:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [16:0] i_clock_angle,
    input  logic signed [15:0] i_deflection_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_x_axis_angle,
    output logic signed [15:0] o_z_axis_angle
);

    localparam int NS = gpaa_pkg::SQRT_STEPS;
    localparam int LAT = 2 * CORDIC_STAGES + NS + 6;

    logic [14:0] r_max_defl;
    logic [LAT-1:0] r_vld;
    logic en;

    assign en = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_defl <= gpaa_pkg::MAX_DEFL_RESET;
        end else if (i_cfg_we) begin
            r_max_defl <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Input stage: wrap the clock angle, fold it into +-90 degrees, clamp the deflection.
    logic signed [18:0] n_cw;
    logic signed [16:0] n_a_ang;
    logic n_a_flip;
    logic signed [15:0] n_dmax, n_a_d;
    logic signed [16:0] r_a_ang;
    logic r_a_flip;
    logic signed [15:0] r_a_d;

    always_comb begin
        unique if (i_clock_angle >= 17'sd46080) begin
            n_cw = 19'(i_clock_angle) - 19'sd92160;
        end else if (i_clock_angle < -17'sd46080) begin
            n_cw = 19'(i_clock_angle) + 19'sd92160;
        end else begin
            n_cw = 19'(i_clock_angle);
        end
        unique if (n_cw > 19'sd23040) begin
            n_a_ang = 17'(19'sd46080 - n_cw);
            n_a_flip = 1'b1;
        end else if (n_cw < -19'sd23040) begin
            n_a_ang = 17'(-19'sd46080 - n_cw);
            n_a_flip = 1'b1;
        end else begin
            n_a_ang = n_cw[16:0];
            n_a_flip = 1'b0;
        end
        n_dmax = (r_max_defl > 15'd23040) ? 16'sd23040 : $signed({1'b0, r_max_defl});
        priority if (i_deflection_angle[15]) begin
            n_a_d = 16'sd0;
        end else if (i_deflection_angle > n_dmax) begin
            n_a_d = n_dmax;
        end else begin
            n_a_d = i_deflection_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ang <= n_a_ang;
            r_a_flip <= n_a_flip;
            r_a_d <= n_a_d;
        end
    end

    // Rotation CORDICs: lane 0 turns the clock angle, lane 1 the deflection.
    logic signed [33:0] r_rx [CORDIC_STAGES][2];
    logic signed [33:0] r_ry [CORDIC_STAGES][2];
    logic signed [31:0] r_rz [CORDIC_STAGES][2];
    logic r_rflip [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
        logic src_flip;
        if (i == 0) begin : g_first
            assign src_flip = r_a_flip;
        end else begin : g_next
            assign src_flip = r_rflip[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rflip[i] <= src_flip;
            end
        end
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [33:0] sx, sy;
            logic signed [31:0] sz;
            if (i == 0) begin : g_first
                assign sx = gpaa_pkg::CORDIC_GAIN;
                assign sy = 34'sd0;
                if (l == 0) begin : g_clk
                    assign sz = 32'(r_a_ang) <<< 14;
                end else begin : g_defl
                    assign sz = 32'(r_a_d) <<< 14;
                end
            end else begin : g_next
                assign sx = r_rx[i-1][l];
                assign sy = r_ry[i-1][l];
                assign sz = r_rz[i-1][l];
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (sz >= 32'sd0) begin
                        r_rx[i][l] <= sx - (sy >>> i);
                        r_ry[i][l] <= sy + (sx >>> i);
                        r_rz[i][l] <= sz - gpaa_pkg::atan_val(i);
                    end else begin
                        r_rx[i][l] <= sx + (sy >>> i);
                        r_ry[i][l] <= sy - (sx >>> i);
                        r_rz[i][l] <= sz + gpaa_pkg::atan_val(i);
                    end
                end
            end
        end
    end

    // Round the clock-angle cosine and sine and the deflection sine, then form and round the two products.
    logic signed [17:0] n_cs;
    logic signed [17:0] r_cs, r_sn, r_sd;
    logic signed [35:0] r_m [2];
    logic signed [17:0] r_p [2];
    logic signed [35:0] r_pp [2];
    logic signed [17:0] r_qp [2];

    assign n_cs = gpaa_pkg::rnd_q16(r_rx[CORDIC_STAGES-1][0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cs <= r_rflip[CORDIC_STAGES-1] ? -n_cs : n_cs;
            r_sn <= gpaa_pkg::rnd_q16(r_ry[CORDIC_STAGES-1][0]);
            r_sd <= gpaa_pkg::rnd_q16(r_ry[CORDIC_STAGES-1][1]);
            r_m[0] <= r_sd * r_cs;
            r_m[1] <= r_sd * r_sn;
            for (int l = 0; l < 2; l++) begin
                r_p[l] <= gpaa_pkg::rnd_prod(r_m[l]);
                r_pp[l] <= r_p[l] * r_p[l];
                r_qp[l] <= r_p[l];
            end
        end
    end

    // Square root of 1 - p*p, one result bit per stage.
    logic [34:0] r_sv [NS][2];
    logic [34:0] r_sr [NS][2];
    logic signed [17:0] r_sp [NS][2];

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        localparam logic [34:0] BIT = 35'(1) << (32 - 2 * k);
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [34:0] sv, sr, sum;
            logic signed [17:0] sp;
            if (k == 0) begin : g_first
                assign sv = (35'(1) << 32) - 35'(r_pp[l][32:0]);
                assign sr = '0;
                assign sp = r_qp[l];
            end else begin : g_next
                assign sv = r_sv[k-1][l];
                assign sr = r_sr[k-1][l];
                assign sp = r_sp[k-1][l];
            end
            assign sum = sr + BIT;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sp[k][l] <= sp;
                    if (sv >= sum) begin
                        r_sv[k][l] <= sv - sum;
                        r_sr[k][l] <= (sr >> 1) + BIT;
                    end else begin
                        r_sv[k][l] <= sv;
                        r_sr[k][l] <= sr >> 1;
                    end
                end
            end
        end
    end

    // Vectoring CORDICs give the arcsine as atan2(p, q).
    logic signed [33:0] r_vx [CORDIC_STAGES][2];
    logic signed [33:0] r_vy [CORDIC_STAGES][2];
    logic signed [31:0] r_vz [CORDIC_STAGES][2];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [33:0] sx, sy;
            logic signed [31:0] sz;
            if (i == 0) begin : g_first
                assign sx = 34'($signed({1'b0, r_sr[NS-1][l][16:0]})) <<< 14;
                assign sy = 34'(r_sp[NS-1][l]) <<< 14;
                assign sz = 32'sd0;
            end else begin : g_next
                assign sx = r_vx[i-1][l];
                assign sy = r_vy[i-1][l];
                assign sz = r_vz[i-1][l];
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (sy >= 34'sd0) begin
                        r_vx[i][l] <= sx + (sy >>> i);
                        r_vy[i][l] <= sy - (sx >>> i);
                        r_vz[i][l] <= sz + gpaa_pkg::atan_val(i);
                    end else begin
                        r_vx[i][l] <= sx - (sy >>> i);
                        r_vy[i][l] <= sy + (sx >>> i);
                        r_vz[i][l] <= sz - gpaa_pkg::atan_val(i);
                    end
                end
            end
        end
    end

    logic signed [15:0] r_xo, r_zo;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xo <= gpaa_pkg::rnd_ang(r_vz[CORDIC_STAGES-1][0]);
            r_zo <= gpaa_pkg::rnd_ang(r_vz[CORDIC_STAGES-1][1]);
        end
    end

    assign o_x_axis_angle = r_xo;
    assign o_z_axis_angle = r_zo;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted word did not enter the pipeline");

    a_defl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_a_d >= 16'sd0 && r_a_d <= 16'sd23040))
        else $error("clamped deflection out of range");

    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_a_ang >= -17'sd23040 && r_a_ang <= 17'sd23040))
        else $error("folded clock angle out of range");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_x_axis_angle >= -16'sd23040 && o_x_axis_angle <= 16'sd23040
                     && o_z_axis_angle >= -16'sd23040 && o_z_axis_angle <= 16'sd23040))
        else $error("output angle out of range");

endmodule
